FILE: hw/rtl/rc4s_pkg.sv
`default_nettype none

package rc4s_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int KEY_LEN    = 8;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = IDX_W + 1;
    localparam int KEY_W      = 64;
    localparam int SEG_W      = 16;
    localparam int KCNT_W     = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SEG_W-1:0] SEG_LEN_RST = SEG_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEG = CFG_IDX_W'(1);

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_port_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rc4_segmented_stream_cipher.sv
`default_nettype none

// RC4 byte cipher with segmented keystream restart. Each accepted byte is XORed
// with the next keystream byte (same operation for encrypt and decrypt). A
// plain byte runs read S[i], read S[j], then two writes for the swap before the
// next acceptance, since the working table has one write port; the third read
// S[t] overlaps the swap with forwarding, and the last write holds while the
// output register is full and not taken. A byte with start_msg set first runs
// key scheduling: a table init of all 256 entries, then per entry a step that
// reads S[n] and S[j] and writes them back swapped. A byte that begins a new
// segment first copies the base table into the working table. The result sits
// in an output register, so the next transaction is accepted while it waits.
module rc4_segmented_stream_cipher (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  wire logic [0:0]                      s_axis_tuser,  // [0] start_msg
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [7:0]                      m_axis_tdata,  // [7:0] out_byte
    input  wire logic                            cfg_we,
    input  wire logic [rc4s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rc4s_pkg::KEY_W-1:0]      cfg_wdata
);

    import rc4s_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [SEG_W-1:0]  seg_len_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic              out_free;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    mem_port_t         base_port;
    mem_port_t         work_port;
    logic [BYTE_W-1:0] base_rdata;
    logic [BYTE_W-1:0] work_rdata;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            seg_len_reg <= SEG_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY: key_reg     <= cfg_wdata;
                CFG_SEG: seg_len_reg <= cfg_wdata[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    rc4s_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_start   (s_axis_tuser[0]),
        .key        (key_reg),
        .seg_len    (seg_len_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_byte   (res_byte),
        .base_port  (base_port),
        .base_rdata (base_rdata),
        .work_port  (work_port),
        .work_rdata (work_rdata)
    );

    rc4s_ram #(
        .DEPTH (TABLE_SIZE),
        .WIDTH (BYTE_W)
    ) u_base_ram (
        .clk   (clk),
        .we    (base_port.we),
        .waddr (base_port.waddr),
        .wdata (base_port.wdata),
        .raddr (base_port.raddr),
        .rdata (base_rdata)
    );

    rc4s_ram #(
        .DEPTH (TABLE_SIZE),
        .WIDTH (BYTE_W)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_port.we),
        .waddr (work_port.waddr),
        .wdata (work_port.wdata),
        .raddr (work_port.raddr),
        .rdata (work_rdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rc4s_ram.sv
`default_nettype none

module rc4s_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rc4s_ctrl.sv
`default_nettype none

module rc4s_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [rc4s_pkg::BYTE_W-1:0] in_data,
    input  wire logic                       in_start,
    input  wire logic [rc4s_pkg::KEY_W-1:0]  key,
    input  wire logic [rc4s_pkg::SEG_W-1:0]  seg_len,
    input  wire logic                       out_free,
    output logic                            res_valid,
    output logic      [rc4s_pkg::BYTE_W-1:0] res_byte,
    output rc4s_pkg::mem_port_t             base_port,
    input  wire logic [rc4s_pkg::BYTE_W-1:0] base_rdata,
    output rc4s_pkg::mem_port_t             work_port,
    input  wire logic [rc4s_pkg::BYTE_W-1:0] work_rdata
);

    import rc4s_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_COPY,
        ST_RD_I,
        ST_RD_J,
        ST_SWAP,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KCNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [SEG_W-1:0]  seg_cnt_reg, seg_cnt_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    logic [SEG_W-1:0]  limit;
    logic              restore;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] ks;
    logic [IDX_W-1:0]  n;

    assign limit   = (seg_len == '0) ? SEG_W'(1) : seg_len;
    assign restore = (seg_cnt_reg >= limit);
    assign kb      = key[k_reg*BYTE_W +: BYTE_W];
    assign n       = cnt_reg[IDX_W-1:0];

    // swap of S[i] and S[j] is not yet fully in the table when S[t] is read
    assign ks = (t_reg == j_reg) ? si_reg :
                (t_reg == i_reg) ? sj_reg : work_rdata;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        t_next       = t_reg;
        seg_cnt_next = seg_cnt_reg;
        data_next    = data_reg;

        base_port       = '0;
        base_port.raddr = n;
        work_port       = '0;
        work_port.raddr = i_reg + 1'b1;

        in_ready  = (state_reg == ST_IDLE);
        res_valid = 1'b0;
        res_byte  = data_reg ^ ks;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = in_data;
                    if (in_start)
                    begin
                        cnt_next   = '0;
                        state_next = ST_INIT;
                    end
                    else if (restore)
                    begin
                        cnt_next   = '0;
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_RD_J;
                    end
                end
            end
            ST_INIT:
            begin
                base_port.we    = 1'b1;
                base_port.waddr = n;
                base_port.wdata = n;
                work_port.we    = 1'b1;
                work_port.waddr = n;
                work_port.wdata = n;
                if (n == IDX_W'(TABLE_SIZE - 1))
                begin
                    cnt_next   = '0;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_KS_RD_N;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_KS_RD_N:
            begin
                base_port.raddr = n;
                state_next      = ST_KS_RD_J;
            end
            ST_KS_RD_J:
            begin
                si_next         = base_rdata;
                j_next          = j_reg + base_rdata + kb;
                base_port.raddr = j_next;
                state_next      = ST_KS_WR_N;
            end
            ST_KS_WR_N:
            begin
                base_port.we    = 1'b1;
                base_port.waddr = n;
                base_port.wdata = base_rdata;
                work_port.we    = 1'b1;
                work_port.waddr = n;
                work_port.wdata = base_rdata;
                state_next      = ST_KS_WR_J;
            end
            ST_KS_WR_J:
            begin
                base_port.we    = 1'b1;
                base_port.waddr = j_reg;
                base_port.wdata = si_reg;
                work_port.we    = 1'b1;
                work_port.waddr = j_reg;
                work_port.wdata = si_reg;
                k_next = (k_reg == KCNT_W'(KEY_LEN - 1)) ? '0 : k_reg + 1'b1;
                if (n == IDX_W'(TABLE_SIZE - 1))
                begin
                    cnt_next     = '0;
                    i_next       = '0;
                    j_next       = '0;
                    seg_cnt_next = '0;
                    state_next   = ST_RD_I;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_KS_RD_N;
                end
            end
            ST_COPY:
            begin
                base_port.raddr = n;
                if (cnt_reg != '0)
                begin
                    work_port.we    = 1'b1;
                    work_port.waddr = IDX_W'(cnt_reg - 1'b1);
                    work_port.wdata = base_rdata;
                end
                if (cnt_reg == CNT_W'(TABLE_SIZE))
                begin
                    cnt_next     = '0;
                    i_next       = '0;
                    j_next       = '0;
                    seg_cnt_next = '0;
                    state_next   = ST_RD_I;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RD_I:
            begin
                work_port.raddr = i_reg + 1'b1;
                i_next          = i_reg + 1'b1;
                state_next      = ST_RD_J;
            end
            ST_RD_J:
            begin
                si_next         = work_rdata;
                j_next          = j_reg + work_rdata;
                work_port.raddr = j_next;
                state_next      = ST_SWAP;
            end
            ST_SWAP:
            begin
                work_port.we    = 1'b1;
                work_port.waddr = i_reg;
                work_port.wdata = work_rdata;
                sj_next         = work_rdata;
                t_next          = si_reg + work_rdata;
                work_port.raddr = t_next;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                work_port.we    = 1'b1;
                work_port.waddr = j_reg;
                work_port.wdata = si_reg;
                work_port.raddr = t_reg;
                if (out_free)
                begin
                    res_valid    = 1'b1;
                    seg_cnt_next = SEG_W'(seg_cnt_reg + 1'b1);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            seg_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            seg_cnt_reg <= seg_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        t_reg    <= t_next;
        data_reg <= data_next;
    end

    a_start_runs_init: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_start) |=> (state_reg == ST_INIT))
        else $error("message start did not enter table init");

    a_restart_clears_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_I) |-> (i_reg == '0 && j_reg == '0 && seg_cnt_reg == '0))
        else $error("keystream restart with nonzero indices");

    a_result_counts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (seg_cnt_reg == SEG_W'($past(seg_cnt_reg) + 1'b1)))
        else $error("segment count not advanced on result");

    a_rdj_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_J) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_RD_I))
        else $error("S[j] read without a fresh S[i] read");

endmodule

`default_nettype wire

FILE: bench/rc4_segmented_stream_cipher_tb.sv
module rc4_segmented_stream_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4s_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic [0:0]           s_axis_tuser = 1'b0;    // [0] start_msg
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;           // [7:0] out_byte
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY;
    logic [KEY_W-1:0]     cfg_wdata = '0;

    rc4_segmented_stream_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    // keystream state mirror
    logic [BYTE_W-1:0] base_tab [TABLE_SIZE];
    logic [BYTE_W-1:0] work_tab [TABLE_SIZE];
    logic [IDX_W-1:0]  ks_i = '0;
    logic [IDX_W-1:0]  ks_j = '0;
    logic [SEG_W-1:0]  seg_cnt = '0;
    logic [KEY_W-1:0]  key_reg = '0;
    logic [SEG_W-1:0]  seg_len_reg = SEG_LEN_RST;

    logic [7:0]  expected_out [$];
    logic [7:0]  want;
    int unsigned errors = 0;
    int unsigned n_bytes = 0;
    int unsigned n_msgs = 0;
    int unsigned n_cfg = 0;
    int unsigned n_results = 0;
    int unsigned stall_cnt = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    function automatic void swap_work(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] tmp;
        tmp         = work_tab[a];
        work_tab[a] = work_tab[b];
        work_tab[b] = tmp;
    endfunction

    function automatic void restore_segment();
        for (int n = 0; n < TABLE_SIZE; n++)
            work_tab[n] = base_tab[n];
        ks_i    = '0;
        ks_j    = '0;
        seg_cnt = '0;
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic start);
        logic [7:0]  jj;
        logic [7:0]  tmp;
        logic [7:0]  t;
        logic [15:0] lim;
        lim = (seg_len_reg == 16'd0) ? 16'd1 : seg_len_reg;
        if (start)
        begin
            for (int n = 0; n < TABLE_SIZE; n++)
                base_tab[n] = n[7:0];
            jj = 8'd0;
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                jj          = jj + base_tab[n] + key_reg[8*(n % KEY_LEN) +: 8];
                tmp         = base_tab[n];
                base_tab[n] = base_tab[jj];
                base_tab[jj] = tmp;
            end
            restore_segment();
        end
        else if (seg_cnt >= lim)
        begin
            restore_segment();
        end
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + work_tab[ks_i];
        swap_work(ks_i, ks_j);
        t = work_tab[ks_i] + work_tab[ks_j];
        seg_cnt = seg_cnt + 16'd1;
        return data ^ work_tab[t];
    endfunction

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("out_byte unexpected transaction: expected none, actual %02h",
                       m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_out.pop_front();
                n_results++;
                if (m_axis_tdata !== want)
                begin
                    $error("out_byte mismatch: expected %02h, actual %02h", want, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results pending",
                         stall_cnt, expected_out.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic st);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= st;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_out.push_back(cipher_byte(d, st));
        n_bytes++;
        if (st)
            n_msgs++;
    endtask

    // drop valid, wait for all results, then let the core go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY)
            key_reg = val;
        else
            seg_len_reg = val[SEG_W-1:0];
        n_cfg++;
    endtask

    task automatic test_key_extremes();
        write_reg(CFG_KEY, 64'h0);
        write_reg(CFG_SEG, 64'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        write_reg(CFG_KEY, {64{1'b1}});
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    task automatic test_segment_restart();
        // zero length restarts before every byte
        write_reg(CFG_SEG, 64'h0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        write_reg(CFG_SEG, 64'd3);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
    endtask

    task automatic test_midmessage_config();
        write_reg(CFG_SEG, 64'd8);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h96, 1'b0);
        // count already past the new length
        write_reg(CFG_SEG, 64'd2);
        send_byte(8'h69, 1'b0);
        send_byte(8'hF0, 1'b0);
        // new key waits for the next message start
        write_reg(CFG_KEY, 64'h0123_4567_89AB_CDEF);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        logic [15:0] seg;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 30)
            begin
                r = $urandom_range(99);
                if (r < 8)
                    seg = 16'd0;
                else if (r < 14)
                    seg = 16'd1;
                else if (r < 20)
                    seg = 16'hFFFF;
                else if (r < 32)
                    seg = 16'($urandom);
                else
                    seg = 16'($urandom_range(64, 2));
                write_reg(CFG_SEG, 64'(seg));
            end
            if ($urandom_range(99) < 40)
                write_reg(CFG_KEY, {$urandom, $urandom});
            r = $urandom_range(99);
            if (r < 80)
                len = $urandom_range(24, 1);
            else if (r < 95)
                len = $urandom_range(120, 25);
            else
                len = $urandom_range(400, 121);
            if (seg_len_reg < 16'd2 && len > 10)
                len = $urandom_range(10, 1);
            send_byte(8'($urandom_range(255)), 1'b1);
            for (int k = 1; k < len; k++)
            begin
                if ($urandom_range(99) < 2)
                begin
                    if ($urandom_range(1) == 0)
                        write_reg(CFG_KEY, {$urandom, $urandom});
                    else if (seg_cnt >= 16'd2)
                        write_reg(CFG_SEG, 64'($urandom_range(seg_cnt, 2)));
                end
                send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 26;
        rx_idle_pct = 75;
        test_key_extremes();
        test_segment_restart();
        test_midmessage_config();
        test_random_traffic(450);

        tx_idle_pct = 75;
        rx_idle_pct = 26;
        test_random_traffic(450);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(450);

        settle();
        if (expected_out.size() != 0)
        begin
            $error("out_byte missing: expected %0d more transactions, actual 0",
                   expected_out.size());
            errors++;
        end

        $display("sent %0d bytes in %0d messages, checked %0d results, %0d register writes",
                 n_bytes, n_msgs, n_results, n_cfg);
        $display("segment lengths 0 to 65535, key changes mid-message, three stall mixes");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: rc4_segmented_stream_cipher.f
hw/rtl/rc4s_pkg.sv
hw/rtl/rc4s_ram.sv
hw/rtl/rc4s_ctrl.sv
hw/rtl/rc4_segmented_stream_cipher.sv
bench/rc4_segmented_stream_cipher_tb.sv
